[rtl/core/esd_pkg.sv]
`default_nettype none
package esd_pkg;

    localparam int NUM_CHOICES = 8;
    localparam int SEL_W       = (NUM_CHOICES > 1) ? $clog2(NUM_CHOICES) : 1;
    localparam int OUT_SEL_W   = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    typedef logic [SEL_W-1:0] t_sel;
    typedef logic [7:0]       t_seg;

    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 2'd3;

    localparam logic [7:0]  RST_BRIGHTNESS = 8'd10;
    localparam logic [9:0]  RST_BLINK      = 10'd200;
    localparam logic [9:0]  RST_HOLD       = 10'd300;
    localparam logic [15:0] RST_DEBOUNCE   = 16'd1000;
    localparam t_sel        RST_SEL        = SEL_W'(1);

    localparam t_seg SEG_BLANK = 8'hFF;

    // common-anode patterns, active low
    function automatic t_seg seg_digit(input logic [3:0] d);
        t_seg s;
        case (d)
            4'd0:    s = 8'hC0;
            4'd1:    s = 8'hF9;
            4'd2:    s = 8'hA4;
            4'd3:    s = 8'hB0;
            4'd4:    s = 8'h99;
            4'd5:    s = 8'h92;
            4'd6:    s = 8'h82;
            4'd7:    s = 8'hF8;
            4'd8:    s = 8'h80;
            4'd9:    s = 8'h90;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

[rtl/core/encoder_selector_segment_display.sv]
`default_nettype none
// Channel   Handshake                  Payload
// input     i_in_valid / o_in_stall    i_kind i_task_active i_time_us i_phase_a i_phase_b
// output    o_out_valid / i_out_stall  o_ones_segments o_tens_segments o_selection
// config    i_cfg_we (no handshake)    i_cfg_index i_cfg_data
//
// One item per cycle sustained while the output is not stalled. An item sits in the input
// register, where the state update and segment lookup run; a tick's frame lands in the
// output register, and o_out_valid rises once the frame is written there.
// Synchronous active-low reset; state, configuration and valid flags return to power-on values.
// An output stall holds the frame and stalls input only once the input register is full.
module encoder_selector_segment_display (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_stall,
    input  wire logic                                 i_kind,
    input  wire logic                                 i_task_active,
    input  wire logic [31:0]                          i_time_us,
    input  wire logic                                 i_phase_a,
    input  wire logic                                 i_phase_b,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_stall,
    output logic [7:0]                                o_ones_segments,
    output logic [7:0]                                o_tens_segments,
    output logic [esd_pkg::OUT_SEL_W-1:0]             o_selection,
    input  wire logic                                 i_cfg_we,
    input  wire logic [esd_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [esd_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    // configuration
    logic [7:0]  r_bright;
    logic [9:0]  r_blink_ticks;
    logic [9:0]  r_hold_ticks;
    logic [15:0] r_debounce;

    // state
    esd_pkg::t_sel r_sel;
    logic [1:0]    r_half;
    logic [31:0]   r_last_time;
    logic [9:0]    r_hold;
    logic [9:0]    r_blink_cnt;
    logic          r_blink_on;
    logic [7:0]    r_strobe;

    // input register
    logic        r_in_valid;
    logic        r_kind;
    logic        r_task;
    logic [31:0] r_time;
    logic        r_pa;
    logic        r_pb;

    // output register
    logic                r_out_valid;
    esd_pkg::t_seg       r_ones;
    esd_pkg::t_seg       r_tens;
    logic [esd_pkg::OUT_SEL_W-1:0] r_sel_out;

    esd_pkg::t_sel n_sel;
    logic [1:0]    n_half;
    logic [31:0]   n_last_time;
    logic [9:0]    n_hold;
    logic [9:0]    n_blink_cnt;
    logic          n_blink_on;
    logic [7:0]    n_strobe;

    logic          w_out_free;
    logic          w_go;
    logic          w_in_acc;
    logic          w_edge_ok;
    logic [31:0]   w_dt;
    logic          w_show;
    logic          w_emit;
    logic          w_blank;
    esd_pkg::t_seg w_ones;
    esd_pkg::t_seg w_tens;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_go        = r_in_valid && w_out_free;
    assign o_in_stall  = r_in_valid && !w_out_free;
    assign w_in_acc    = i_in_valid && !o_in_stall;

    assign w_dt      = r_time - r_last_time;
    assign w_edge_ok = r_kind && !r_task && (w_dt >= {16'd0, r_debounce});

    esd_seg_enc u_seg (
        .i_sel  (r_sel),
        .i_show (w_show),
        .o_ones (w_ones),
        .o_tens (w_tens)
    );

    always_comb begin
        n_sel       = r_sel;
        n_half      = r_half;
        n_last_time = r_last_time;
        n_hold      = r_hold;
        n_blink_cnt = r_blink_cnt;
        n_blink_on  = r_blink_on;
        n_strobe    = r_strobe;
        w_show      = 1'b1;
        w_emit      = 1'b0;
        w_blank     = 1'b0;
        if (r_kind) begin
            if (w_edge_ok) begin
                n_last_time = r_time;
                n_hold      = r_hold_ticks;
                // half-step count held as two-bit signed, -1..1
                if (r_pa == r_pb) begin
                    if (r_half == 2'b11) begin
                        n_half = 2'b00;
                        if (r_sel == '0 ||
                            {1'b0, r_sel} >= (esd_pkg::SEL_W + 1)'(esd_pkg::NUM_CHOICES)) begin
                            n_sel = esd_pkg::SEL_W'(esd_pkg::NUM_CHOICES - 1);
                        end else begin
                            n_sel = r_sel - esd_pkg::SEL_W'(1);
                        end
                    end else begin
                        n_half = r_half - 2'd1;
                    end
                end else begin
                    if (r_half == 2'b01) begin
                        n_half = 2'b00;
                        if ({1'b0, r_sel} + (esd_pkg::SEL_W + 1)'(1) >=
                                (esd_pkg::SEL_W + 1)'(esd_pkg::NUM_CHOICES)) begin
                            n_sel = '0;
                        end else begin
                            n_sel = r_sel + esd_pkg::SEL_W'(1);
                        end
                    end else begin
                        n_half = r_half + 2'd1;
                    end
                end
            end
        end else begin
            if (!r_task && r_hold == 10'd0) begin
                if (r_blink_cnt == 10'd0) begin
                    n_blink_on  = !r_blink_on;
                    n_blink_cnt = r_blink_ticks;
                end else begin
                    n_blink_cnt = r_blink_cnt - 10'd1;
                end
                w_show = n_blink_on;
            end
            if (r_strobe == r_bright) begin
                w_emit   = 1'b1;
                w_blank  = 1'b1;
                n_strobe = r_strobe - 8'd1;
            end else if (r_strobe == 8'd0) begin
                w_emit   = 1'b1;
                n_strobe = r_bright;
            end else begin
                n_strobe = r_strobe - 8'd1;
            end
            if (r_hold != 10'd0) begin
                n_hold = r_hold - 10'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bright      <= esd_pkg::RST_BRIGHTNESS;
            r_blink_ticks <= esd_pkg::RST_BLINK;
            r_hold_ticks  <= esd_pkg::RST_HOLD;
            r_debounce    <= esd_pkg::RST_DEBOUNCE;
            r_sel         <= esd_pkg::RST_SEL;
            r_half        <= 2'b00;
            r_last_time   <= 32'd0;
            r_hold        <= 10'd0;
            r_blink_cnt   <= 10'd0;
            r_blink_on    <= 1'b0;
            r_strobe      <= 8'd0;
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    esd_pkg::CFG_BRIGHTNESS: r_bright      <= i_cfg_data[7:0];
                    esd_pkg::CFG_BLINK:      r_blink_ticks <= i_cfg_data[9:0];
                    esd_pkg::CFG_HOLD:       r_hold_ticks  <= i_cfg_data[9:0];
                    esd_pkg::CFG_DEBOUNCE:   r_debounce    <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (w_go) begin
                r_sel       <= n_sel;
                r_half      <= n_half;
                r_last_time <= n_last_time;
                r_hold      <= n_hold;
                r_blink_cnt <= n_blink_cnt;
                r_blink_on  <= n_blink_on;
                r_strobe    <= n_strobe;
            end
            if (w_in_acc) begin
                r_in_valid <= 1'b1;
            end else if (w_go) begin
                r_in_valid <= 1'b0;
            end
            if (w_go && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_kind <= i_kind;
            r_task <= i_task_active;
            r_time <= i_time_us;
            r_pa   <= i_phase_a;
            r_pb   <= i_phase_b;
        end
        if (w_go && w_emit) begin
            r_ones    <= w_blank ? esd_pkg::SEG_BLANK : w_ones;
            r_tens    <= w_blank ? esd_pkg::SEG_BLANK : w_tens;
            r_sel_out <= esd_pkg::OUT_SEL_W'(r_sel);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_ones_segments = r_ones;
    assign o_tens_segments = r_tens;
    assign o_selection     = r_sel_out;

    a_in_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_in_valid)
        else $error("accepted item not held in input register");

    a_sel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_sel} < (esd_pkg::SEL_W + 1)'(esd_pkg::NUM_CHOICES))
        else $error("selection out of range");

    a_half_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_half != 2'b10)
        else $error("half-step count overflow");

    a_frame_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_go && !r_kind))
        else $error("frame not caused by a display tick");

    a_hold_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_go && w_edge_ok) |=> (r_hold == $past(r_hold_ticks)))
        else $error("hold count not loaded by accepted edge");

endmodule
`default_nettype wire

[rtl/core/esd_seg_enc.sv]
`default_nettype none
module esd_seg_enc (
    input  wire esd_pkg::t_sel i_sel,
    input  wire logic          i_show,
    output esd_pkg::t_seg      o_ones,
    output esd_pkg::t_seg      o_tens
);

    logic [3:0] w_tens;
    logic [3:0] w_ones;
    logic [7:0] w_val;

    assign w_val = 8'(i_sel);

    // tens digit by threshold compare, value stays below 100
    always_comb begin
        w_tens = 4'd0;
        for (int k = 1; k < 10; k++) begin
            if (w_val >= 8'(k * 10)) begin
                w_tens = 4'(k);
            end
        end
        w_ones = 4'(w_val - 8'(w_tens) * 8'd10);
    end

    always_comb begin
        o_ones = esd_pkg::SEG_BLANK;
        o_tens = esd_pkg::SEG_BLANK;
        if (i_show) begin
            o_ones = esd_pkg::seg_digit(w_ones);
            if (w_tens != 4'd0) begin
                o_tens = esd_pkg::seg_digit(w_tens);
            end
        end
    end

endmodule
`default_nettype wire

[tb/esd_frame_checker.sv]
`timescale 1ns / 100ps
module esd_frame_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    input  wire logic                           i_in_stall,
    input  wire logic                           i_kind,
    input  wire logic                           i_task_active,
    input  wire logic [31:0]                    i_time_us,
    input  wire logic                           i_phase_a,
    input  wire logic                           i_phase_b,
    input  wire logic                           i_out_valid,
    input  wire logic                           i_out_stall,
    input  wire logic [7:0]                     i_ones_segments,
    input  wire logic [7:0]                     i_tens_segments,
    input  wire logic [esd_pkg::OUT_SEL_W-1:0]  i_selection,
    input  wire logic                           i_cfg_we,
    input  wire logic [esd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [esd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                                  o_errors,
    output int                                  o_pending
);

    typedef struct packed {
        esd_pkg::t_seg                 ones;
        esd_pkg::t_seg                 tens;
        logic [esd_pkg::OUT_SEL_W-1:0] sel;
    } t_frame;

    // active-low digit patterns 0..9
    localparam esd_pkg::t_seg DIGIT_SEGS [10] = '{
        8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
    };

    t_frame      frames_due[$];

    logic [7:0]  bright_period;
    logic [9:0]  blink_reload;
    logic [9:0]  hold_reload;
    logic [15:0] debounce_gap;

    int          sel_now;
    int          half_cnt;
    logic [31:0] last_edge_us;
    logic [9:0]  hold_left;
    logic [9:0]  blink_left;
    logic        blink_phase;
    logic [7:0]  strobe_left;

    task automatic reset_model();
        bright_period = esd_pkg::RST_BRIGHTNESS;
        blink_reload  = esd_pkg::RST_BLINK;
        hold_reload   = esd_pkg::RST_HOLD;
        debounce_gap  = esd_pkg::RST_DEBOUNCE;
        sel_now       = 1;
        half_cnt      = 0;
        last_edge_us  = '0;
        hold_left     = '0;
        blink_left    = '0;
        blink_phase   = 1'b0;
        strobe_left   = '0;
    endtask

    task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
        if (o_errors < 100)
            $display("%0t mismatch on %s: got %0h, want %0h", $time, what, got, want);
        o_errors++;
    endtask

    function automatic void count_edge(input logic [31:0] t, input logic a, input logic b);
        logic [31:0] since;
        since = t - last_edge_us;
        if (since < {16'd0, debounce_gap})
            return;
        last_edge_us = t;
        if (a == b)
            half_cnt--;
        else
            half_cnt++;
        if (half_cnt >= 2) begin
            half_cnt = 0;
            sel_now  = (sel_now + 1 >= esd_pkg::NUM_CHOICES) ? 0 : sel_now + 1;
        end else if (half_cnt <= -2) begin
            half_cnt = 0;
            sel_now  = (sel_now == 0 || sel_now >= esd_pkg::NUM_CHOICES) ?
                       esd_pkg::NUM_CHOICES - 1 : sel_now - 1;
        end
        hold_left = hold_reload;
    endfunction

    // returns 1 when the item yields a frame
    function automatic bit predict_frame(input logic kind, input logic busy,
                                         input logic [31:0] t, input logic a, input logic b,
                                         output t_frame f);
        bit show;
        bit got;
        int v;
        got = 1'b0;
        f   = '0;
        if (kind) begin
            if (!busy)
                count_edge(t, a, b);
            return 1'b0;
        end
        if (!busy && hold_left == 0) begin
            if (blink_left == 0) begin
                blink_phase = ~blink_phase;
                blink_left  = blink_reload;
            end else begin
                blink_left--;
            end
            show = blink_phase;
        end else begin
            show = 1'b1;
        end
        f.sel = esd_pkg::OUT_SEL_W'(sel_now);
        if (strobe_left == bright_period) begin
            f.ones      = esd_pkg::SEG_BLANK;
            f.tens      = esd_pkg::SEG_BLANK;
            strobe_left = strobe_left - 8'd1;
            got         = 1'b1;
        end else if (strobe_left == 0) begin
            f.ones = esd_pkg::SEG_BLANK;
            f.tens = esd_pkg::SEG_BLANK;
            if (show) begin
                v      = sel_now % 100;
                f.ones = DIGIT_SEGS[v % 10];
                if (v / 10 != 0)
                    f.tens = DIGIT_SEGS[v / 10];
            end
            strobe_left = bright_period;
            got         = 1'b1;
        end else begin
            strobe_left = strobe_left - 8'd1;
        end
        if (hold_left != 0)
            hold_left--;
        return got;
    endfunction

    always @(posedge i_clk) begin : watch
        t_frame f;
        if (!i_rst_n) begin
            reset_model();
            frames_due.delete();
            o_errors  = 0;
            o_pending = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (frames_due.size() == 0) begin
                    report("unexpected frame", i_ones_segments, 8'h00);
                end else begin
                    f = frames_due.pop_front();
                    if (i_ones_segments !== f.ones)
                        report("ones_segments", i_ones_segments, f.ones);
                    if (i_tens_segments !== f.tens)
                        report("tens_segments", i_tens_segments, f.tens);
                    if (i_selection !== f.sel)
                        report("selection", 8'(i_selection), 8'(f.sel));
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    esd_pkg::CFG_BRIGHTNESS: bright_period = i_cfg_data[7:0];
                    esd_pkg::CFG_BLINK:      blink_reload  = i_cfg_data[9:0];
                    esd_pkg::CFG_HOLD:       hold_reload   = i_cfg_data[9:0];
                    esd_pkg::CFG_DEBOUNCE:   debounce_gap  = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                if (predict_frame(i_kind, i_task_active, i_time_us, i_phase_a, i_phase_b, f))
                    frames_due.push_back(f);
            end
            o_pending = frames_due.size();
        end
    end

endmodule

[tb/encoder_selector_segment_display_tb.sv]
`timescale 1ns / 100ps
module encoder_selector_segment_display_tb;

    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_EDGE = 1'b1;

    logic                           i_clk         = 1'b0;
    logic                           i_rst_n       = 1'b0;
    logic                           i_in_valid    = 1'b0;
    logic                           i_kind        = 1'b0;
    logic                           i_task_active = 1'b0;
    logic [31:0]                    i_time_us     = '0;
    logic                           i_phase_a     = 1'b0;
    logic                           i_phase_b     = 1'b0;
    logic                           i_out_stall   = 1'b0;
    logic                           i_cfg_we      = 1'b0;
    logic [esd_pkg::CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [esd_pkg::CFG_DATA_W-1:0] i_cfg_data    = '0;

    logic                           o_in_stall;
    logic                           o_out_valid;
    logic [7:0]                     o_ones_segments;
    logic [7:0]                     o_tens_segments;
    logic [esd_pkg::OUT_SEL_W-1:0]  o_selection;

    int                    errors;
    int                    pending;

    logic [31:0]           clock_us     = '0;
    logic [15:0]           cur_debounce = esd_pkg::RST_DEBOUNCE;
    bit                    enc_up       = 1'b1;
    bit                    send_burst   = 1'b0;
    bit                    recv_burst   = 1'b0;
    int                    stall_left   = 0;
    int                    stall_draw;

    encoder_selector_segment_display dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_kind          (i_kind),
        .i_task_active   (i_task_active),
        .i_time_us       (i_time_us),
        .i_phase_a       (i_phase_a),
        .i_phase_b       (i_phase_b),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_ones_segments (o_ones_segments),
        .o_tens_segments (o_tens_segments),
        .o_selection     (o_selection),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    esd_frame_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_kind          (i_kind),
        .i_task_active   (i_task_active),
        .i_time_us       (i_time_us),
        .i_phase_a       (i_phase_a),
        .i_phase_b       (i_phase_b),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_ones_segments (o_ones_segments),
        .i_tens_segments (o_tens_segments),
        .i_selection     (o_selection),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_errors        (errors),
        .o_pending       (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver: stall after a frame, or at random while idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else if (i_out_stall) begin
            if (stall_left == 0)
                i_out_stall <= 1'b0;
            else
                stall_left <= stall_left - 1;
        end else begin
            stall_draw = 0;
            if (o_out_valid) begin
                stall_draw = recv_burst ? 0 : $urandom_range(0, 13);
                if ($urandom_range(0, 29) == 0)
                    recv_burst <= ~recv_burst;
            end else if (!recv_burst && $urandom_range(0, 19) == 0) begin
                stall_draw = $urandom_range(1, 13);
            end
            if (stall_draw != 0) begin
                i_out_stall <= 1'b1;
                stall_left  <= stall_draw - 1;
            end
        end
    end

    task automatic send_item(input logic kind, input logic busy, input logic [31:0] t,
                             input logic a, input logic b);
        int gap;
        i_in_valid    <= 1'b1;
        i_kind        <= kind;
        i_task_active <= busy;
        i_time_us     <= t;
        i_phase_a     <= a;
        i_phase_b     <= b;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        if ($urandom_range(0, 39) == 0)
            send_burst = ~send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 13);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (pending != 0);
        // edges leave no frame, give the pipe time to settle
        repeat (4) @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [7:0] bright, input logic [9:0] blink,
                                input logic [9:0] hold, input logic [15:0] debounce);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= esd_pkg::CFG_BRIGHTNESS;
        i_cfg_data  <= 16'(bright);
        @(posedge i_clk);
        i_cfg_index <= esd_pkg::CFG_BLINK;
        i_cfg_data  <= 16'(blink);
        @(posedge i_clk);
        i_cfg_index <= esd_pkg::CFG_HOLD;
        i_cfg_data  <= 16'(hold);
        @(posedge i_clk);
        i_cfg_index <= esd_pkg::CFG_DEBOUNCE;
        i_cfg_data  <= debounce;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_debounce = debounce;
    endtask

    task automatic random_items(input int n);
        int   pick;
        logic a;
        logic b;
        logic busy;
        repeat (n) begin
            a = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 99) < 55) begin
                busy = ($urandom_range(0, 9) == 0);
                b    = 1'($urandom_range(0, 1));
                send_item(KIND_TICK, busy, $urandom, a, b);
            end else begin
                busy = ($urandom_range(0, 11) == 0);
                pick = $urandom_range(0, 9);
                if (pick < 7)
                    clock_us = clock_us + cur_debounce + $urandom_range(0, 1500);
                else if (pick < 9)
                    clock_us = clock_us + $urandom_range(0, cur_debounce);
                else
                    clock_us = $urandom;
                if ($urandom_range(0, 7) == 0)
                    enc_up = ~enc_up;
                // mostly a steady rotation, now and then a reversed half-step
                b = (enc_up ^ ($urandom_range(0, 9) == 0)) ? ~a : a;
                send_item(KIND_EDGE, busy, clock_us, a, b);
            end
        end
    endtask

    task automatic run_phase(input logic [7:0] bright, input logic [9:0] blink,
                             input logic [9:0] hold, input logic [15:0] debounce, input int n);
        drain();
        program_regs(bright, blink, hold, debounce);
        random_items(n);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: blink on, strobe frames, debounce edges, wrap both ways
        send_item(KIND_TICK, 1'b0, 32'h0000_0000, 1'b0, 1'b0);
        send_item(KIND_TICK, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1);
        send_item(KIND_EDGE, 1'b1, 32'd5000, 1'b0, 1'b1);
        send_item(KIND_EDGE, 1'b0, 32'd999, 1'b0, 1'b0);
        send_item(KIND_EDGE, 1'b0, 32'd1000, 1'b0, 1'b0);
        send_item(KIND_EDGE, 1'b0, 32'd2000, 1'b1, 1'b1);
        send_item(KIND_EDGE, 1'b0, 32'd3000, 1'b0, 1'b0);
        send_item(KIND_EDGE, 1'b0, 32'd4000, 1'b1, 1'b1);
        send_item(KIND_TICK, 1'b0, 32'd0, 1'b0, 1'b0);
        send_item(KIND_EDGE, 1'b0, 32'd5000, 1'b0, 1'b1);
        send_item(KIND_EDGE, 1'b0, 32'd6000, 1'b1, 1'b0);
        send_item(KIND_EDGE, 1'b0, 32'd7000, 1'b0, 1'b1);
        send_item(KIND_EDGE, 1'b0, 32'd8000, 1'b1, 1'b0);
        send_item(KIND_EDGE, 1'b0, 32'hFFFF_FFFF, 1'b1, 1'b0);
        send_item(KIND_EDGE, 1'b0, 32'h0000_03E6, 1'b0, 1'b1);
        send_item(KIND_EDGE, 1'b0, 32'h0000_03E7, 1'b0, 1'b1);
        repeat (6)
            send_item(KIND_TICK, 1'b0, 32'hA5A5_5A5A, 1'b1, 1'b0);
        clock_us = 32'h0000_03E7;

        run_phase(8'd1,   10'd0,    10'd0,    16'd0,     260);
        run_phase(8'd2,   10'd3,    10'd6,    16'd40,    300);
        run_phase(8'd255, 10'd1023, 10'd1023, 16'd65535, 160);
        // zero period: blank frames only, one per 256 ticks
        run_phase(8'd0,   10'd1,    10'd2,    16'd1,     280);
        run_phase(8'd4,   10'd9,    10'd15,   16'd300,   300);
        run_phase(esd_pkg::RST_BRIGHTNESS, esd_pkg::RST_BLINK, esd_pkg::RST_HOLD,
                  esd_pkg::RST_DEBOUNCE, 120);
        drain();

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
